@@ design/sjdm_pkg.sv @@
// Shared types, register codes and constants for the sync jitter and delay monitor.
// No dependencies; every other file of the block imports this package.
package sjdm_pkg;

    localparam int SampleW = 64;
    localparam int ResultW = 32;
    localparam int LogW    = 4;
    localparam int CfgIdxW = 2;

    localparam logic MODE_SYNC  = 1'b0;
    localparam logic MODE_DELAY = 1'b1;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_INTERVAL_LOG    = 2'd0,
        CFG_JITTER_LIMIT    = 2'd1,
        CFG_VARIATION_LIMIT = 2'd2
    } cfg_index_t;

    localparam logic [LogW-1:0]    IntervalLogReset    = 4'hD;   // -3
    localparam logic [ResultW-1:0] JitterLimitReset    = 32'd1000;
    localparam logic [ResultW-1:0] VariationLimitReset = 32'd10000;

    localparam logic [SampleW-1:0] NsPerSecond = 64'd1_000_000_000;

    typedef struct packed {
        logic               mode;
        logic [SampleW-1:0] sample_value;
    } event_t;

    typedef struct packed {
        logic [LogW-1:0]    interval_log;
        logic [ResultW-1:0] jitter_limit;
        logic [ResultW-1:0] variation_limit;
    } cfg_t;

    // Nominal sync period: one second scaled by 2^log, truncating on right shifts.
    function automatic logic [SampleW-1:0] nominal_sync_period(input logic [LogW-1:0] code);
        logic [LogW-1:0] shamt;
        shamt = '0;
        if (!code[LogW-1]) begin
            nominal_sync_period = NsPerSecond << code[LogW-2:0];
        end else begin
            shamt = LogW'(0) - code;   // magnitude of a negative log, 1 to 8
            nominal_sync_period = NsPerSecond >> shamt;
        end
    endfunction

endpackage

@@ design/sjdm_in_stage.sv @@
// Input register stage of the monitor: holds one event transfer.
// Depends on sjdm_pkg for the event type.
module sjdm_in_stage import sjdm_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  event_t s_evt,
    output logic   evt_valid,
    input  logic   evt_ready,
    output event_t evt
);

    logic   valid_reg;
    event_t evt_reg;

    // Take a new event whenever the stage is empty or is being drained.
    assign s_ready   = !valid_reg || evt_ready;
    assign evt_valid = valid_reg;
    assign evt       = evt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            evt_reg <= s_evt;
        end
    end

endmodule

@@ design/sjdm_core.sv @@
// Monitor datapath: previous-value state, jitter and variation update, result register.
// Depends on sjdm_pkg for event and configuration types and the nominal sync period.
module sjdm_core import sjdm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               evt_valid,
    output logic               evt_ready,
    input  event_t             evt,
    input  cfg_t               cfg,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [ResultW-1:0] m_jitter_ns,
    output logic [ResultW-1:0] m_variation_ns,
    output logic [ResultW-1:0] m_sync_total,
    output logic               m_jitter_ok,
    output logic               m_delay_ok,
    output logic               m_compliant
);

    logic               valid_reg;
    logic [SampleW-1:0] prev_arrival_reg, prev_arrival_next;
    logic [SampleW-1:0] prev_delay_reg, prev_delay_next;
    logic [ResultW-1:0] jitter_reg, jitter_next;
    logic [ResultW-1:0] variation_reg, variation_next;
    logic [ResultW-1:0] sync_count_reg, sync_count_next;
    logic               advance;
    logic [SampleW-1:0] interval;

    function automatic logic [ResultW-1:0] abs_diff_sat(input logic [SampleW-1:0] a,
                                                         input logic [SampleW-1:0] b);
        logic [SampleW:0]   a_minus_b;
        logic [SampleW-1:0] d;
        a_minus_b = {1'b0, a} - {1'b0, b};
        d = a_minus_b[SampleW] ? (b - a) : a_minus_b[SampleW-1:0];
        abs_diff_sat = (|d[SampleW-1:ResultW]) ? '1 : d[ResultW-1:0];
    endfunction

    assign advance   = evt_valid && evt_ready;
    assign evt_ready = !valid_reg || m_ready;
    assign interval  = evt.sample_value - prev_arrival_reg;

    always_comb begin
        prev_arrival_next = prev_arrival_reg;
        prev_delay_next   = prev_delay_reg;
        jitter_next       = jitter_reg;
        variation_next    = variation_reg;
        sync_count_next   = sync_count_reg;
        if (evt.mode == MODE_SYNC) begin
            sync_count_next = sync_count_reg + ResultW'(1);
            if (prev_arrival_reg != '0) begin
                jitter_next = abs_diff_sat(interval, nominal_sync_period(cfg.interval_log));
            end
            prev_arrival_next = evt.sample_value;
        end else begin
            if (prev_delay_reg != '0) begin
                variation_next = abs_diff_sat(evt.sample_value, prev_delay_reg);
            end
            prev_delay_next = evt.sample_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg        <= 1'b0;
            prev_arrival_reg <= '0;
            prev_delay_reg   <= '0;
            jitter_reg       <= '0;
            variation_reg    <= '0;
            sync_count_reg   <= '0;
        end else begin
            if (evt_ready) begin
                valid_reg <= evt_valid;
            end
            if (advance) begin
                prev_arrival_reg <= prev_arrival_next;
                prev_delay_reg   <= prev_delay_next;
                jitter_reg       <= jitter_next;
                variation_reg    <= variation_next;
                sync_count_reg   <= sync_count_next;
            end
        end
    end

    // Limits are to be changed only while idle (the block does not enforce this), so compare against the held result.
    assign m_valid        = valid_reg;
    assign m_jitter_ns    = jitter_reg;
    assign m_variation_ns = variation_reg;
    assign m_sync_total   = sync_count_reg;
    assign m_jitter_ok    = jitter_reg <= cfg.jitter_limit;
    assign m_delay_ok     = variation_reg <= cfg.variation_limit;
    assign m_compliant    = m_jitter_ok && m_delay_ok;

endmodule

@@ design/sync_jitter_delay_monitor_unit.sv @@
// Top level of the sync jitter and path delay variation monitor.
// Depends on sjdm_pkg, sjdm_in_stage and sjdm_core.
//
// Each input transfer is either a sync arrival time (mode 0) or a path delay
// sample (mode 1), and produces exactly one result transfer. A sync arrival
// bumps the 32-bit wrapping sync count and, when an earlier nonzero arrival is
// held, sets the jitter to |interval - expected| where the expected interval
// is 1e9 ns scaled by two to the power of the configured interval log. A delay
// sample sets the variation to its distance from the previous nonzero sample.
// Both saturate at 0xFFFFFFFF; a stored value of zero counts as nothing seen.
// The block takes one transfer per cycle while m_ready keeps the result channel
// draining: an event passes an input register, then the update logic (one
// 64-bit subtract and an absolute difference) into the result register.
// Configuration is written through cfg_wen/cfg_index/cfg_wdata and must only
// be changed while no results are pending.
module sync_jitter_delay_monitor_unit import sjdm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration write port
    input  logic               cfg_wen,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [ResultW-1:0] cfg_wdata,
    // event channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic [SampleW-1:0] s_sample_value,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [ResultW-1:0] m_jitter_ns,
    output logic [ResultW-1:0] m_variation_ns,
    output logic [ResultW-1:0] m_sync_total,
    output logic               m_jitter_ok,
    output logic               m_delay_ok,
    output logic               m_compliant
);

    cfg_t   cfg_reg;
    event_t s_evt;
    event_t evt;
    logic   evt_valid;
    logic   evt_ready;

    // Hold configuration; writes to an unused index drop silently.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.interval_log    <= IntervalLogReset;
            cfg_reg.jitter_limit    <= JitterLimitReset;
            cfg_reg.variation_limit <= VariationLimitReset;
        end else if (cfg_wen) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_INTERVAL_LOG:    cfg_reg.interval_log    <= cfg_wdata[LogW-1:0];
                CFG_JITTER_LIMIT:    cfg_reg.jitter_limit    <= cfg_wdata;
                CFG_VARIATION_LIMIT: cfg_reg.variation_limit <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_evt.mode         = s_mode;
    assign s_evt.sample_value = s_sample_value;

    // Register the incoming transfer to keep the update path short.
    sjdm_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_evt     (s_evt),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt)
    );

    // Update state and hold the result until the consumer takes it.
    sjdm_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .evt_valid      (evt_valid),
        .evt_ready      (evt_ready),
        .evt            (evt),
        .cfg            (cfg_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_jitter_ns    (m_jitter_ns),
        .m_variation_ns (m_variation_ns),
        .m_sync_total   (m_sync_total),
        .m_jitter_ok    (m_jitter_ok),
        .m_delay_ok     (m_delay_ok),
        .m_compliant    (m_compliant)
    );

endmodule
